/* sv/lwkd_pkg.sv */
// shared constants, types and control store for the k-distinct window core
package lwkd_pkg;

  localparam int unsigned MaxWindowDef    = 1024;
  localparam int unsigned AlphabetSizeDef = 26;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned BestW    = 11;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [CfgW-1:0] MaxDistinctRst = 5'd2;
  // register select is paddr[2] (word index)
  localparam logic RegMaxDistinct = 1'b0;

  typedef logic [3:0] upc_t;

  localparam upc_t UpcIdle   = 4'd0;
  localparam upc_t UpcOvRing = 4'd1;
  localparam upc_t UpcOvCnt  = 4'd2;
  localparam upc_t UpcOvDec  = 4'd3;
  localparam upc_t UpcAddCnt = 4'd4;
  localparam upc_t UpcAddInc = 4'd5;
  localparam upc_t UpcFinish = 4'd6;
  localparam upc_t UpcDrRing = 4'd7;
  localparam upc_t UpcDrCnt  = 4'd8;
  localparam upc_t UpcDrDec  = 4'd9;

  typedef enum logic [1:0] {
    CondGo,
    CondDispatch,
    CondFinish
  } cond_e;

  typedef struct packed {
    logic  rd_ring;
    logic  rd_cnt_old;
    logic  rd_cnt_new;
    logic  dec;
    logic  inc;
    cond_e cond;
    upc_t  next;
    upc_t  alt;
  } ctrl_t;

  // control store: one word per step
  function automatic ctrl_t ucode(upc_t upc);
    ctrl_t w;
    w = '{rd_ring: 1'b0, rd_cnt_old: 1'b0, rd_cnt_new: 1'b0, dec: 1'b0, inc: 1'b0,
          cond: CondGo, next: UpcIdle, alt: UpcIdle};
    case (upc)
      UpcIdle: begin
        w.rd_cnt_new = 1'b1;
        w.cond       = CondDispatch;
        w.next       = UpcOvRing;
        w.alt        = UpcAddInc;
      end
      UpcOvRing: begin
        w.rd_ring = 1'b1;
        w.next    = UpcOvCnt;
      end
      UpcOvCnt: begin
        w.rd_cnt_old = 1'b1;
        w.next       = UpcOvDec;
      end
      UpcOvDec: begin
        w.dec  = 1'b1;
        w.next = UpcAddCnt;
      end
      UpcAddCnt: begin
        w.rd_cnt_new = 1'b1;
        w.next       = UpcAddInc;
      end
      UpcAddInc: begin
        w.inc  = 1'b1;
        w.next = UpcFinish;
      end
      UpcFinish: begin
        w.cond = CondFinish;
        w.next = UpcIdle;
        w.alt  = UpcDrRing;
      end
      UpcDrRing: begin
        w.rd_ring = 1'b1;
        w.next    = UpcDrCnt;
      end
      UpcDrCnt: begin
        w.rd_cnt_old = 1'b1;
        w.next       = UpcDrDec;
      end
      UpcDrDec: begin
        w.dec  = 1'b1;
        w.next = UpcFinish;
      end
      default: begin
        w.next = UpcIdle;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/longest_window_k_distinct_core.sv */
// longest window with at most k distinct letters, microcoded sequencer
// a letter that drops nothing steps through idle, add-inc and finish; each dropped letter adds a ring read,
// a count read and a decrement, a full ring first adds an overflow drop, and an out-of-range letter goes to finish
// one item at a time: ready is high only in the idle step, which follows the result load;
// the finish step waits while a result is held downstream
// reset is asynchronous: control, count valid bits and max_distinct (2) clear; ring not cleared
module longest_window_k_distinct_core #(
  parameter int unsigned MAX_WINDOW    = lwkd_pkg::MaxWindowDef,
  parameter int unsigned ALPHABET_SIZE = lwkd_pkg::AlphabetSizeDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [lwkd_pkg::InTdataW-1:0]  s_axis_tdata_i,  // [4:0] letter
  input  logic                           s_axis_tlast_i,  // end_of_string
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [lwkd_pkg::OutTdataW-1:0] m_axis_tdata_o,  // [10:0] best_length, [11] window_overflow
  output logic                           m_axis_tlast_o,  // string_done
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [lwkd_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [lwkd_pkg::ApbDataW-1:0]  pwdata_i,
  output logic [lwkd_pkg::ApbDataW-1:0]  prdata_o,
  output logic                           pready_o
);
  import lwkd_pkg::*;

  localparam int unsigned PtrW  = $clog2(MAX_WINDOW);
  localparam int unsigned SizeW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AddrW = $clog2(ALPHABET_SIZE);
  localparam int unsigned DistW = $clog2(ALPHABET_SIZE + 1);
  localparam logic [SizeW-1:0] SizeMax = SizeW'(MAX_WINDOW);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(MAX_WINDOW - 1);
  localparam logic [PtrW:0]    RingLen = (PtrW + 1)'(MAX_WINDOW);

  function automatic logic [AddrW-1:0] to_idx(logic [LetterW-1:0] c);
    logic [AddrW+LetterW-1:0] w;
    w = (AddrW + LetterW)'(c);
    return w[AddrW-1:0];
  endfunction

  function automatic logic [BestW-1:0] to_best(logic [SizeW-1:0] v);
    logic [SizeW+BestW-1:0] w;
    w = (SizeW + BestW)'(v);
    return w[BestW-1:0];
  endfunction

  logic [LetterW-1:0] ring_mem [MAX_WINDOW];
  logic [SizeW-1:0]   cnt_mem  [ALPHABET_SIZE];

  upc_t                 upc_q, upc_d;
  logic [CfgW-1:0]      max_distinct_q;
  logic [ALPHABET_SIZE-1:0] cnt_vld_q;
  logic [DistW-1:0]     distinct_q;
  logic [PtrW-1:0]      head_q;
  logic [SizeW-1:0]     size_q;
  logic [SizeW-1:0]     best_q;
  logic                 good_q, last_q, ovf_q;
  logic                 out_vld_q, out_last_q, out_ovf_q;
  logic [BestW-1:0]     out_best_q;
  logic [LetterW-1:0]   code_q, ring_q;
  logic [SizeW-1:0]     cnt_q;

  ctrl_t                ctrl;
  logic [LetterW-1:0]   letter;
  logic                 in_fire, in_good, full, over_limit, out_free, fin_fire;
  logic                 cnt_rd, cfg_wr, cfg_hit;
  logic [LetterW-1:0]   cnt_code;
  logic [AddrW-1:0]     cnt_idx;
  logic [PtrW:0]        tail_sum, tail_adj;
  logic [PtrW-1:0]      tail_ptr;
  logic [SizeW-1:0]     best_new;

  assign ctrl       = ucode(upc_q);
  assign letter     = s_axis_tdata_i[LetterW-1:0];
  assign s_axis_tready_o = (upc_q == UpcIdle);
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_good    = int'(letter) < int'(ALPHABET_SIZE);
  assign full       = (size_q == SizeMax);
  assign over_limit = good_q && (int'(distinct_q) > int'(max_distinct_q)) && (size_q != '0);
  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign fin_fire   = (upc_q == UpcFinish) && !over_limit && out_free;
  assign best_new   = (size_q > best_q) ? size_q : best_q;

  assign tail_sum = {1'b0, head_q} + (PtrW + 1)'(size_q);
  assign tail_adj = (tail_sum >= RingLen) ? tail_sum - RingLen : tail_sum;
  assign tail_ptr = tail_adj[PtrW-1:0];

  // count lookup: oldest letter while dropping, else the new letter
  assign cnt_code = ctrl.rd_cnt_old ? ring_q : ((upc_q == UpcIdle) ? letter : code_q);
  assign cnt_idx  = to_idx(cnt_code);
  assign cnt_rd   = ctrl.rd_cnt_old ||
                    (ctrl.rd_cnt_new && ((upc_q != UpcIdle) || (in_fire && in_good)));

  assign cfg_hit  = (paddr_i[2] == RegMaxDistinct);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o && cfg_hit;
  assign pready_o = 1'b1;
  assign prdata_o = cfg_hit ? ApbDataW'(max_distinct_q) : '0;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW - BestW - 1){1'b0}}, out_ovf_q, out_best_q};
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    upc_d = upc_q;
    case (ctrl.cond)
      CondGo: begin
        upc_d = ctrl.next;
      end
      CondDispatch: begin
        if (in_fire) begin
          if (!in_good) begin
            upc_d = UpcFinish;
          end else if (full) begin
            upc_d = ctrl.next;
          end else begin
            upc_d = ctrl.alt;
          end
        end
      end
      CondFinish: begin
        if (over_limit) begin
          upc_d = ctrl.alt;
        end else if (out_free) begin
          upc_d = ctrl.next;
        end
      end
      default: begin
        upc_d = UpcIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q          <= UpcIdle;
      max_distinct_q <= MaxDistinctRst;
      cnt_vld_q      <= '0;
      distinct_q     <= '0;
      head_q         <= '0;
      size_q         <= '0;
      best_q         <= '0;
      good_q         <= 1'b0;
      last_q         <= 1'b0;
      ovf_q          <= 1'b0;
      out_vld_q      <= 1'b0;
      out_last_q     <= 1'b0;
      out_ovf_q      <= 1'b0;
      out_best_q     <= '0;
    end else begin
      upc_q <= upc_d;
      if (cfg_wr) begin
        max_distinct_q <= pwdata_i[CfgW-1:0];
      end
      if (in_fire) begin
        good_q <= in_good;
        last_q <= s_axis_tlast_i;
        ovf_q  <= in_good && full;
      end
      if (ctrl.inc) begin
        cnt_vld_q[to_idx(code_q)] <= 1'b1;
        if (cnt_q == '0) begin
          distinct_q <= distinct_q + DistW'(1);
        end
        size_q <= size_q + SizeW'(1);
      end
      if (ctrl.dec) begin
        if (cnt_q == SizeW'(1) && distinct_q != '0) begin
          distinct_q <= distinct_q - DistW'(1);
        end
        head_q <= (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
        if (size_q != '0) begin
          size_q <= size_q - SizeW'(1);
        end
      end
      if (fin_fire) begin
        out_vld_q  <= 1'b1;
        out_best_q <= to_best(best_new);
        out_last_q <= last_q;
        out_ovf_q  <= ovf_q;
        if (last_q) begin
          cnt_vld_q  <= '0;
          distinct_q <= '0;
          head_q     <= '0;
          size_q     <= '0;
          best_q     <= '0;
        end else begin
          best_q <= best_new;
        end
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // memories and datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q <= letter;
    end
    if (ctrl.rd_ring) begin
      ring_q <= ring_mem[head_q];
    end
    if (ctrl.inc) begin
      ring_mem[tail_ptr]      <= code_q;
      cnt_mem[to_idx(code_q)] <= cnt_q + SizeW'(1);
    end
    if (ctrl.dec && cnt_q != '0) begin
      cnt_mem[to_idx(ring_q)] <= cnt_q - SizeW'(1);
    end
    if (cnt_rd) begin
      cnt_q <= cnt_vld_q[cnt_idx] ? cnt_mem[cnt_idx] : '0;
    end
  end

endmodule

/* sv/lwkd_checker.sv */
// port-level checks for the k-distinct window core, bound to the top level
module lwkd_checker #(
  parameter int unsigned MAX_WINDOW = lwkd_pkg::MaxWindowDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [lwkd_pkg::OutTdataW-1:0] m_axis_tdata_o,  // [10:0] best_length, [11] window_overflow
  input logic                           m_axis_tlast_o   // string_done
);
  import lwkd_pkg::*;

  localparam logic [BestW-1:0] MaxBest  = BestW'(MAX_WINDOW);
  localparam logic             BestWrap = (MAX_WINDOW > 2047);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // one item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item accepted while busy");

  // best length saturates at the ring size
  a_best_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> BestWrap || (m_axis_tdata_o[BestW-1:0] <= MaxBest))
    else $error("best length above ring size");

  // overflow only happens once the window has filled the ring
  a_ovf_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[BestW] |-> m_axis_tdata_o[BestW-1:0] == MaxBest)
    else $error("overflow without full window");

endmodule

bind longest_window_k_distinct_core lwkd_checker #(.MAX_WINDOW(MAX_WINDOW)) u_lwkd_checker (.*);

/* sim/longest_window_k_distinct_core_tb.sv */
// self-checking testbench for the longest k-distinct window core
module longest_window_k_distinct_core_tb;
  import lwkd_pkg::*;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 20;
  localparam int NumDirected = 23;
  localparam int PhaseItems = 60;
  localparam int LongStringLen = 1040;

  typedef struct packed {
    logic [BestW-1:0] best;
    logic             done;
    logic             ovf;
  } window_result_t;

  typedef struct packed {
    logic               cfg_wr;
    logic [CfgW-1:0]    cfg_val;
    logic [LetterW-1:0] code;
    logic               eos;
    logic               typed;
    window_result_t     res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_valid = 1'b0;
  logic [InTdataW-1:0]  s_data = '0;
  logic                 s_last = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutTdataW-1:0] m_data;
  logic                 m_last;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ApbAddrW-1:0]  paddr = '0;
  logic [ApbDataW-1:0]  pwdata = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  longest_window_k_distinct_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // [4:0] letter
    .s_axis_tlast_i (s_last),   // end_of_string
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),   // [10:0] best_length, [11] window_overflow
    .m_axis_tlast_o (m_last),   // string_done
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model of the window state
  logic [LetterW-1:0] ring_copy [MaxWindowDef];
  int unsigned        letter_tally [AlphabetSizeDef];
  int unsigned        distinct_now;
  int unsigned        head_idx;
  int unsigned        win_len;
  int unsigned        best_len;
  logic [CfgW-1:0]    k_limit;

  window_result_t pending_results [$];
  int mismatches = 0;
  int src_idle_pct = 17;
  int sink_idle_pct = 66;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  dir_row_t dir_tab [NumDirected];

  function automatic void clear_string_state();
    for (int c = 0; c < AlphabetSizeDef; c++) letter_tally[c] = 0;
    distinct_now = 0;
    head_idx = 0;
    win_len = 0;
    best_len = 0;
  endfunction

  function automatic void drop_oldest_letter();
    int unsigned c;
    if (win_len == 0) return;
    c = ring_copy[head_idx];
    if (c < AlphabetSizeDef && letter_tally[c] > 0) begin
      letter_tally[c]--;
      if (letter_tally[c] == 0 && distinct_now > 0) distinct_now--;
    end
    head_idx++;
    if (head_idx >= MaxWindowDef) head_idx = 0;
    win_len--;
  endfunction

  function automatic window_result_t predict_window(logic [LetterW-1:0] code, logic eos);
    window_result_t r;
    int unsigned tail;
    logic ovf;
    ovf = 1'b0;
    if (code < AlphabetSizeDef) begin
      if (win_len >= MaxWindowDef) begin
        drop_oldest_letter();
        ovf = 1'b1;
      end
      tail = head_idx + win_len;
      if (tail >= MaxWindowDef) tail -= MaxWindowDef;
      ring_copy[tail] = code;
      win_len++;
      if (letter_tally[code] == 0) distinct_now++;
      letter_tally[code]++;
      while (distinct_now > k_limit && win_len > 0) drop_oldest_letter();
      if (win_len > best_len) best_len = win_len;
      if (best_len > MaxWindowDef) best_len = MaxWindowDef;
    end
    r.best = best_len[BestW-1:0];
    r.done = eos;
    r.ovf  = ovf;
    if (eos) clear_string_state();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    window_result_t want;
    if (m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_data[BestW-1:0], 0);
      end else begin
        want = pending_results.pop_front();
        if (m_data[BestW-1:0] !== want.best)
          report_mismatch("best_length", m_data[BestW-1:0], want.best);
        if (m_last !== want.done) report_mismatch("string_done", m_last, want.done);
        if (m_data[BestW] !== want.ovf) report_mismatch("window_overflow", m_data[BestW], want.ovf);
      end
    end
    if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin
    if (holds_served != hold_requests && hold_left == 0) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_letter(input logic [LetterW-1:0] code, input logic eos,
                             input logic typed, input window_result_t typed_res);
    window_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InTdataW-LetterW){1'b0}}, code};
    s_last  <= eos;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    r = predict_window(code, eos);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_max_distinct(input logic [CfgW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {{(ApbDataW-CfgW){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    k_limit = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {{(ApbDataW-CfgW){1'b0}}, val}) report_mismatch("max_distinct readback", prdata, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_limit();
    case ($urandom_range(5))
      0: return 5'd0;
      1: return 5'd26;
      2: return 5'd1;
      3: return 5'd2;
      4: return 5'd3;
      default: return CfgW'($urandom_range(26));
    endcase
  endfunction

  task automatic send_random_string(output int n);
    int len;
    int spread;
    int base;
    int r;
    logic [LetterW-1:0] code;
    len = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(16, 1);
    // mostly a narrow alphabet just wider than the limit, so drops happen
    spread = int'(k_limit) + 1 + $urandom_range(1);
    if (spread > AlphabetSizeDef) spread = AlphabetSizeDef;
    base = $urandom_range(AlphabetSizeDef - spread);
    for (int j = 0; j < len; j++) begin
      r = $urandom_range(99);
      if (r < 6) code = LetterW'($urandom_range(31, AlphabetSizeDef));
      else if (r < 14) code = LetterW'($urandom_range(AlphabetSizeDef - 1));
      else code = LetterW'(base + $urandom_range(spread - 1));
      send_letter(code, j == len - 1, 1'b0, '0);
    end
    n = len;
  endtask

  initial begin
    int sent;
    int n;
    dir_tab = '{
      '{1'b0, 5'd0,  5'd0,  1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{1'b0, 5'd0,  5'd1,  1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
      '{1'b0, 5'd0,  5'd2,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd31, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd26, 1'b1, 1'b0, '0},
      '{1'b0, 5'd0,  5'd31, 1'b1, 1'b1, '{11'd0, 1'b1, 1'b0}},
      '{1'b0, 5'd0,  5'd25, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{1'b0, 5'd0,  5'd25, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd16, 1'b1, 1'b0, '0},
      // limit of zero keeps the window empty
      '{1'b1, 5'd0,  5'd3,  1'b0, 1'b1, '{11'd0, 1'b0, 1'b0}},
      '{1'b0, 5'd0,  5'd24, 1'b1, 1'b1, '{11'd0, 1'b1, 1'b0}},
      // full alphabet never forces a drop
      '{1'b1, 5'd26, 5'd0,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd25, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd5,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd10, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd31, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd20, 1'b1, 1'b0, '0},
      '{1'b1, 5'd1,  5'd7,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd7,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd8,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd8,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd8,  1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  5'd9,  1'b1, 1'b0, '0}
    };
    for (int i = 0; i < MaxWindowDef; i++) ring_copy[i] = '0;
    clear_string_state();
    k_limit = MaxDistinctRst;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      if (dir_tab[i].cfg_wr) begin
        drain_results();
        write_max_distinct(dir_tab[i].cfg_val);
      end
      send_letter(dir_tab[i].code, dir_tab[i].eos, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 17;
          sink_idle_pct = 66;
        end
        1: begin
          src_idle_pct = 66;
          sink_idle_pct = 17;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
          hold_requests++;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(3) == 0) begin
          drain_results();
          write_max_distinct(pick_limit());
        end
        send_random_string(n);
        sent += n;
      end
      if (phase == 2) begin
        // one string past the ring size: overflow and saturation of best_length
        drain_results();
        write_max_distinct(5'd3);
        for (int j = 0; j < LongStringLen; j++)
          send_letter(LetterW'($urandom_range(2)), j == LongStringLen - 1, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lwkd_pkg.sv
sv/longest_window_k_distinct_core.sv
sv/lwkd_checker.sv
sim/longest_window_k_distinct_core_tb.sv
